>>> design/rlgsd_pkg.sv
// ----------------------------------------------------------------------------
// rlgsd_pkg
// Shared types and constants of the run-length glyph span decoder.
// ----------------------------------------------------------------------------
package rlgsd_pkg;

	localparam int CW      = 16;
	localparam int RSC_W   = CW + 1;
	localparam int ROW_W   = CW + 1;
	localparam int COL_W   = CW + 2;
	localparam int END_W   = CW + 3;
	localparam int CC_W    = 9;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [7:0] ALPHA_RESET = 8'hff;

	typedef enum logic [2:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_RIGHT  = 3'd1,
		REG_CLIP_TOP    = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_OFFSET_X    = 3'd4,
		REG_OFFSET_Y    = 3'd5,
		REG_WIDTH       = 3'd6,
		REG_ALPHA       = 3'd7
	} reg_idx_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	typedef struct packed {
		logic signed [CW-1:0] clip_left;
		logic signed [CW-1:0] clip_right;
		logic signed [CW-1:0] clip_top;
		logic signed [CW-1:0] clip_bottom;
		logic [7:0]           glyph_offset_x;
		logic [7:0]           glyph_offset_y;
		logic [7:0]           glyph_width;
		logic [7:0]           glyph_alpha;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_t;

	typedef struct packed {
		logic                 span_valid;
		logic signed [CW-1:0] row_y;
		logic signed [CW-1:0] pair_start_x;
		logic signed [CW-1:0] first_x;
		logic signed [CW-1:0] last_x;
		logic [7:0]           alpha_even;
		logic [7:0]           alpha_odd;
		logic                 glyph_done;
	} out_t;

endpackage

>>> design/rlgsd_cfg.sv
// ----------------------------------------------------------------------------
// rlgsd_cfg
// APB register bank holding the clip window, glyph offsets, width and alpha.
// ----------------------------------------------------------------------------
module rlgsd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rlgsd_pkg::ADDR_W-1:0] paddr,
	input  logic [rlgsd_pkg::DATA_W-1:0] pwdata,
	output logic [rlgsd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output rlgsd_pkg::cfg_t             cfg
);
	import rlgsd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q             <= '0;
			cfg_q.glyph_alpha <= ALPHA_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_CLIP_LEFT:   cfg_q.clip_left      <= pwdata[CW-1:0];
				REG_CLIP_RIGHT:  cfg_q.clip_right     <= pwdata[CW-1:0];
				REG_CLIP_TOP:    cfg_q.clip_top       <= pwdata[CW-1:0];
				REG_CLIP_BOTTOM: cfg_q.clip_bottom    <= pwdata[CW-1:0];
				REG_OFFSET_X:    cfg_q.glyph_offset_x <= pwdata[7:0];
				REG_OFFSET_Y:    cfg_q.glyph_offset_y <= pwdata[7:0];
				REG_WIDTH:       cfg_q.glyph_width    <= pwdata[7:0];
				REG_ALPHA:       cfg_q.glyph_alpha    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_CLIP_LEFT:   prdata = DATA_W'($unsigned(cfg_q.clip_left));
			REG_CLIP_RIGHT:  prdata = DATA_W'($unsigned(cfg_q.clip_right));
			REG_CLIP_TOP:    prdata = DATA_W'($unsigned(cfg_q.clip_top));
			REG_CLIP_BOTTOM: prdata = DATA_W'($unsigned(cfg_q.clip_bottom));
			REG_OFFSET_X:    prdata = DATA_W'(cfg_q.glyph_offset_x);
			REG_OFFSET_Y:    prdata = DATA_W'(cfg_q.glyph_offset_y);
			REG_WIDTH:       prdata = DATA_W'(cfg_q.glyph_width);
			REG_ALPHA:       prdata = DATA_W'(cfg_q.glyph_alpha);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> design/rlgsd_core.sv
// ----------------------------------------------------------------------------
// rlgsd_core
// Decoder state and the single-pass span logic for one coded byte.
// ----------------------------------------------------------------------------
module rlgsd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  rlgsd_pkg::cfg_t cfg,
	input  rlgsd_pkg::in_t  item,
	input  logic            advance,
	output logic            res_valid,
	output rlgsd_pkg::out_t res
);
	import rlgsd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [7:0]                run_q, run_d;
	logic [CC_W-1:0]           cc_q, cc_d;
	logic signed [RSC_W-1:0]   rsc_q, rsc_d;
	logic signed [ROW_W-1:0]   row_q, row_d;
	logic [7:0]                skip_q, skip_d;
	logic                      fin_q, fin_d;

	logic [7:0]                n;
	logic [CC_W-1:0]           two_n;
	logic [CC_W:0]             cc_sum;
	logic signed [COL_W-1:0]   col;
	logic signed [END_W-1:0]   col_e, end_x, cl_e, cr_e, fx, lx;
	logic signed [ROW_W-1:0]   cb_e, row_inc;
	logic [7:0]                ae, ao;
	logic                      span_ok, run_done, row_end;

	// nibble * 17 * alpha / 255, truncating
	function automatic logic [7:0] scale(input logic [3:0] nib, input logic [7:0] a);
		logic [15:0] p;
		logic [15:0] s;
		p = {8'd0, nib, nib} * {8'd0, a};
		s = p + {8'd0, p[15:8]} + 16'd1;
		return s[15:8];
	endfunction

	assign n      = (phase_q == PH_REPEAT) ? run_q : 8'd1;
	assign two_n  = {n, 1'b0};
	assign cc_sum = {1'b0, cc_q} + {1'b0, two_n};
	assign col    = $signed({rsc_q[RSC_W-1], rsc_q}) +
		$signed({{(COL_W-CC_W){1'b0}}, cc_q});
	assign col_e  = {col[COL_W-1], col};
	assign end_x  = col_e + $signed({{(END_W-CC_W){1'b0}}, two_n}) - END_W'(1);
	assign cl_e   = {{(END_W-CW){cfg.clip_left[CW-1]}}, cfg.clip_left};
	assign cr_e   = {{(END_W-CW){cfg.clip_right[CW-1]}}, cfg.clip_right};
	assign fx     = (col_e < cl_e) ? cl_e : col_e;
	assign lx     = (end_x > cr_e) ? cr_e : end_x;
	assign ae     = scale(item.data_byte[3:0], cfg.glyph_alpha);
	assign ao     = scale(item.data_byte[7:4], cfg.glyph_alpha);
	assign cb_e   = {cfg.clip_bottom[CW-1], cfg.clip_bottom};
	assign row_inc = row_q + ROW_W'(1);

	always_comb begin
		span_ok = 1'b0;
		if (fx <= lx) begin
			if (fx < lx)
				span_ok = (ae != 8'd0) || (ao != 8'd0);
			else if (fx[0] ^ col_e[0])
				span_ok = (ao != 8'd0);
			else
				span_ok = (ae != 8'd0);
		end
	end

	always_comb begin
		phase_d   = phase_q;
		run_d     = run_q;
		cc_d      = cc_q;
		rsc_d     = rsc_q;
		row_d     = row_q;
		skip_d    = skip_q;
		fin_d     = fin_q;
		res_valid = 1'b0;
		res       = '0;
		run_done  = 1'b0;
		row_end   = 1'b0;
		if (item.command == CMD_START) begin
			skip_d  = cfg.glyph_offset_y;
			rsc_d   = $signed({cfg.clip_left[CW-1], cfg.clip_left}) -
				$signed({{(RSC_W-8){1'b0}}, cfg.glyph_offset_x});
			row_d   = {cfg.clip_top[CW-1], cfg.clip_top};
			cc_d    = '0;
			phase_d = PH_HEADER;
			run_d   = '0;
			fin_d   = (cfg.glyph_alpha == 8'd0) || (cfg.glyph_width == 8'd0) ||
				(cfg.clip_bottom < cfg.clip_top);
			if (fin_d) begin
				res_valid      = 1'b1;
				res.glyph_done = 1'b1;
			end
		end else if (!fin_q) begin
			case (phase_q)
				PH_HEADER: begin
					if (item.data_byte[7]) begin
						phase_d = PH_REPEAT;
						run_d   = {1'b0, item.data_byte[6:0]} + 8'd1;
					end else begin
						phase_d = PH_LITERAL;
						run_d   = item.data_byte + 8'd1;
					end
				end
				PH_REPEAT, PH_LITERAL: begin
					cc_d = cc_sum[CC_W-1:0];
					if (phase_q == PH_REPEAT) begin
						run_d    = '0;
						run_done = 1'b1;
					end else begin
						run_d    = run_q - 8'd1;
						run_done = (run_d == 8'd0);
					end
					if (run_done)
						phase_d = PH_HEADER;
					row_end = run_done && (cc_sum >= {2'b0, cfg.glyph_width});
					if (row_end) begin
						cc_d = '0;
						if (skip_q != 8'd0) begin
							skip_d = skip_q - 8'd1;
						end else begin
							row_d = row_inc;
							if (row_inc > cb_e)
								fin_d = 1'b1;
						end
					end
					if (skip_q == 8'd0) begin
						res_valid        = 1'b1;
						res.span_valid   = span_ok;
						res.row_y        = row_q[CW-1:0];
						res.pair_start_x = col[CW-1:0];
						res.first_x      = span_ok ? fx[CW-1:0] : '0;
						res.last_x       = span_ok ? lx[CW-1:0] : '0;
						res.alpha_even   = span_ok ? ae : 8'd0;
						res.alpha_odd    = span_ok ? ao : 8'd0;
						res.glyph_done   = fin_d;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			run_q   <= '0;
			cc_q    <= '0;
			rsc_q   <= '0;
			row_q   <= '0;
			skip_q  <= '0;
			fin_q   <= 1'b1;
		end else if (advance) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			cc_q    <= cc_d;
			rsc_q   <= rsc_d;
			row_q   <= row_d;
			skip_q  <= skip_d;
			fin_q   <= fin_d;
		end
	end

endmodule

>>> design/rle_4bit_glyph_span_decoder.sv
// ----------------------------------------------------------------------------
// rle_4bit_glyph_span_decoder
// Run-length 4-bit-alpha glyph decoder producing clipped, alpha-scaled spans.
// ----------------------------------------------------------------------------
// path: a byte is held in the input register, and its span is then captured in the result register
// throughput: one byte per cycle while the output is not stalled, set by the input register to result register pass
// the decoder state updates as each byte leaves the input register
// reset: pipeline empty, decoder finished until a start, glyph_alpha 255, others 0
module rle_4bit_glyph_span_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  rlgsd_pkg::in_t              in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output rlgsd_pkg::out_t             out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rlgsd_pkg::ADDR_W-1:0] paddr,
	input  logic [rlgsd_pkg::DATA_W-1:0] pwdata,
	output logic [rlgsd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import rlgsd_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic valid_s1;
	logic advance;
	logic res_valid;
	out_t res;
	out_t res_s2;
	logic valid_s2;

	rlgsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rlgsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	assign advance   = valid_s1 & ~(valid_s2 & out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= res_valid;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_data;
		if (advance && res_valid)
			res_s2 <= res;
	end

endmodule

>>> bench/rlgsd_span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlgsd_span_checker
// Passive checker for the run-length glyph span decoder. It snoops the register
// port to keep its own copy of the window and brush settings, decodes every
// accepted byte transaction with an independent model of the decoder, and
// compares each accepted span transaction in order with the oldest prediction.
// ----------------------------------------------------------------------------
module rlgsd_span_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  rlgsd_pkg::in_t               in_data,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  rlgsd_pkg::out_t              out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rlgsd_pkg::ADDR_W-1:0] paddr,
	input  logic [rlgsd_pkg::DATA_W-1:0] pwdata,
	input  logic                         pready,
	output int                           fail_count,
	output int                           pending
);
	import rlgsd_pkg::*;

	typedef enum logic [1:0] {AWAIT_HEADER, IN_REPEAT, IN_LITERAL} phase_t;

	cfg_t       shadow;
	phase_t     phase;
	logic [7:0] run_left;
	int         col_in_row;
	longint     row_origin;
	longint     row_now;
	logic [7:0] skip_left;
	bit         glyph_over;
	out_t       expected_spans[$];
	int         errs;

	function automatic logic [7:0] scaled(input logic [3:0] nib);
		int unsigned a;
		a = 32'(nib);
		a = a * 17 * shadow.glyph_alpha / 255;
		return a[7:0];
	endfunction

	function automatic string span_str(input out_t s);
		return $sformatf("valid=%0b y=%0d px=%0d fx=%0d lx=%0d ae=%0d ao=%0d done=%0b",
			s.span_valid, s.row_y, s.pair_start_x, s.first_x, s.last_x,
			s.alpha_even, s.alpha_odd, s.glyph_done);
	endfunction

	function automatic void decode_byte(input in_t t);
		longint     cl, cr, ct, cb;
		longint     c, e, fx, lx, rowv, d;
		int         gw, n;
		bit         vis, ok;
		logic [7:0] ae, ao;
		out_t       r;
		cl = longint'(shadow.clip_left);
		cr = longint'(shadow.clip_right);
		ct = longint'(shadow.clip_top);
		cb = longint'(shadow.clip_bottom);
		gw = int'(shadow.glyph_width);
		r  = '0;
		if (t.command == CMD_START) begin
			skip_left  = shadow.glyph_offset_y;
			row_origin = cl - longint'(shadow.glyph_offset_x);
			row_now    = ct;
			col_in_row = 0;
			phase      = AWAIT_HEADER;
			run_left   = '0;
			glyph_over = (shadow.glyph_alpha == 8'd0) || (gw == 0) || (cb < ct);
			if (glyph_over) begin
				r.glyph_done = 1'b1;
				expected_spans.push_back(r);
			end
			return;
		end
		if (glyph_over)
			return;
		if (phase == AWAIT_HEADER) begin
			if (t.data_byte[7]) begin
				phase    = IN_REPEAT;
				run_left = {1'b0, t.data_byte[6:0]} + 8'd1;
			end else begin
				phase    = IN_LITERAL;
				run_left = t.data_byte + 8'd1;
			end
			return;
		end
		n    = (phase == IN_REPEAT) ? int'(run_left) : 1;
		vis  = (skip_left == 8'd0);
		c    = row_origin + col_in_row;
		e    = c + 2 * n - 1;
		fx   = (c < cl) ? cl : c;
		lx   = (e > cr) ? cr : e;
		ae   = scaled(t.data_byte[3:0]);
		ao   = scaled(t.data_byte[7:4]);
		rowv = row_now;
		ok   = 1'b0;
		if (fx <= lx) begin
			d = fx - c;
			if (fx < lx)
				ok = (ae != 8'd0) || (ao != 8'd0);
			else
				ok = d[0] ? (ao != 8'd0) : (ae != 8'd0);
		end
		col_in_row += 2 * n;
		if (phase == IN_REPEAT) begin
			run_left = '0;
			phase    = AWAIT_HEADER;
		end else begin
			run_left = run_left - 8'd1;
			if (run_left == 8'd0)
				phase = AWAIT_HEADER;
		end
		// a row closes only when a run completes at or past the glyph width
		if (phase == AWAIT_HEADER && col_in_row >= gw) begin
			col_in_row = 0;
			if (skip_left > 8'd0) begin
				skip_left = skip_left - 8'd1;
			end else begin
				row_now++;
				if (row_now > cb)
					glyph_over = 1'b1;
			end
		end
		if (!vis)
			return;
		r.span_valid   = ok;
		r.row_y        = rowv[CW-1:0];
		r.pair_start_x = c[CW-1:0];
		if (ok) begin
			r.first_x    = fx[CW-1:0];
			r.last_x     = lx[CW-1:0];
			r.alpha_even = ae;
			r.alpha_odd  = ao;
		end
		r.glyph_done = glyph_over;
		expected_spans.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_t want;
		out_t got;
		if (!arst_n) begin
			shadow             = '0;
			shadow.glyph_alpha = ALPHA_RESET;
			phase              = AWAIT_HEADER;
			run_left           = '0;
			col_in_row         = 0;
			row_origin         = 0;
			row_now            = 0;
			skip_left          = '0;
			glyph_over         = 1'b1;
			expected_spans.delete();
			errs               = 0;
			fail_count        <= 0;
			pending           <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_CLIP_LEFT:   shadow.clip_left      = pwdata[CW-1:0];
					REG_CLIP_RIGHT:  shadow.clip_right     = pwdata[CW-1:0];
					REG_CLIP_TOP:    shadow.clip_top       = pwdata[CW-1:0];
					REG_CLIP_BOTTOM: shadow.clip_bottom    = pwdata[CW-1:0];
					REG_OFFSET_X:    shadow.glyph_offset_x = pwdata[7:0];
					REG_OFFSET_Y:    shadow.glyph_offset_y = pwdata[7:0];
					REG_WIDTH:       shadow.glyph_width    = pwdata[7:0];
					REG_ALPHA:       shadow.glyph_alpha    = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte(in_data);
			if (out_valid && !out_stall) begin
				got = out_data;
				if (expected_spans.size() == 0) begin
					if (errs < 10)
						$display("unexpected span at %0t: %s", $time, span_str(got));
					errs++;
				end else begin
					want = expected_spans.pop_front();
					if (want.span_valid !== got.span_valid ||
					    want.row_y !== got.row_y ||
					    want.pair_start_x !== got.pair_start_x ||
					    want.first_x !== got.first_x ||
					    want.last_x !== got.last_x ||
					    want.alpha_even !== got.alpha_even ||
					    want.alpha_odd !== got.alpha_odd ||
					    want.glyph_done !== got.glyph_done) begin
						if (errs < 10)
							$display("span mismatch at %0t: expected %s, got %s",
								$time, span_str(want), span_str(got));
						errs++;
					end
				end
			end
			fail_count <= errs;
			pending    <= expected_spans.size();
		end
	end

endmodule

>>> bench/rle_4bit_glyph_span_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_4bit_glyph_span_decoder_tb
// Top of the decoder bench. Programs the draw window through the register
// port while the block is idle, then feeds coded glyph byte transactions:
// a directed set of corner cases followed by random well-formed glyphs with
// some noise, under bursty input and random output back-pressure. Checking
// is left to the checker instance; this module only reports the verdict.
// ----------------------------------------------------------------------------
module rle_4bit_glyph_span_decoder_tb;
	import rlgsd_pkg::*;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_t               in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_t              out_data;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                fail_count;
	int                pending;

	int burst_left = 0;
	int items_sent = 0;
	int stall_pct  = 0;
	int stall_left = 0;

	rle_4bit_glyph_span_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rlgsd_span_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// receiver back-pressure in stretches of differing density
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(16, 400);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		stall_left--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_window(input cfg_t c);
		logic [DATA_W-1:0] v;
		v = $urandom; v[CW-1:0] = c.clip_left;      write_reg(REG_CLIP_LEFT, v);
		v = $urandom; v[CW-1:0] = c.clip_right;     write_reg(REG_CLIP_RIGHT, v);
		v = $urandom; v[CW-1:0] = c.clip_top;       write_reg(REG_CLIP_TOP, v);
		v = $urandom; v[CW-1:0] = c.clip_bottom;    write_reg(REG_CLIP_BOTTOM, v);
		v = $urandom; v[7:0]    = c.glyph_offset_x; write_reg(REG_OFFSET_X, v);
		v = $urandom; v[7:0]    = c.glyph_offset_y; write_reg(REG_OFFSET_Y, v);
		v = $urandom; v[7:0]    = c.glyph_width;    write_reg(REG_WIDTH, v);
		v = $urandom; v[7:0]    = c.glyph_alpha;    write_reg(REG_ALPHA, v);
	endtask

	task automatic push(input logic cmd, input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= '{command: cmd, data_byte: b};
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// drain every outstanding span, then let the pipeline empty
	task automatic settle(input int tail);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (tail) @(posedge clk);
	endtask

	function automatic logic [7:0] pair_byte();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(0, 5))
			0: b[3:0] = 4'h0;
			1: b[7:4] = 4'h0;
			2: b = 8'h00;
			3: b = 8'hff;
			default: ;
		endcase
		return b;
	endfunction

	function automatic logic [CW-1:0] edge_coord();
		case ($urandom_range(0, 2))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		int   kind;
		int   v;
		kind = $urandom_range(0, 11);
		if (kind == 0) begin
			c.clip_left      = edge_coord();
			c.clip_right     = edge_coord();
			c.clip_top       = edge_coord();
			c.clip_bottom    = edge_coord();
			c.glyph_offset_x = ($urandom_range(0, 1) != 0) ? 8'hff : 8'($urandom);
			case ($urandom_range(0, 2))
				0: c.glyph_offset_y = 8'hff;
				1: c.glyph_offset_y = 8'h00;
				default: c.glyph_offset_y = 8'($urandom_range(0, 15));
			endcase
			c.glyph_width    = ($urandom_range(0, 1) != 0) ? 8'hff : 8'($urandom);
			c.glyph_alpha    = 8'($urandom);
			return c;
		end
		v = $urandom_range(0, 60) - 20;
		c.clip_left = CW'(v);
		v = v + $urandom_range(0, 32) - 3;
		c.clip_right = CW'(v);
		v = $urandom_range(0, 40) - 20;
		c.clip_top = CW'(v);
		v = v + $urandom_range(0, 4);
		c.clip_bottom = CW'(v);
		c.glyph_offset_x = 8'($urandom_range(0, 12));
		c.glyph_offset_y = 8'($urandom_range(0, 3));
		c.glyph_width    = 8'($urandom_range(1, 24));
		case ($urandom_range(0, 5))
			0, 1:    c.glyph_alpha = 8'hff;
			2:       c.glyph_alpha = 8'($urandom_range(1, 16));
			default: c.glyph_alpha = 8'($urandom_range(1, 255));
		endcase
		if (kind == 1) begin
			case ($urandom_range(0, 2))
				0: c.glyph_alpha = 8'h00;
				1: c.glyph_width = 8'h00;
				default: c.clip_bottom = c.clip_top - 16'sd1;
			endcase
		end else if (kind == 2) begin
			c.clip_right = c.clip_left - 16'sd1;
		end
		return c;
	endfunction

	task automatic send_glyph(input cfg_t c);
		int         vis, rows, gw, cols, cnt;
		logic [7:0] hb;
		gw = int'(c.glyph_width);
		if (c.glyph_alpha == 8'h00 || gw == 0 || c.clip_bottom < c.clip_top) begin
			push(CMD_START, 8'($urandom));
			push(CMD_DATA, 8'($urandom));
			push(CMD_DATA, 8'($urandom));
			return;
		end
		vis = int'(c.clip_bottom) - int'(c.clip_top) + 1;
		if (vis > ((gw > 64) ? 2 : 5))
			vis = (gw > 64) ? 2 : 5;
		rows = int'(c.glyph_offset_y) + vis + int'($urandom_range(0, 1));
		push(CMD_START, 8'($urandom));
		for (int r = 0; r < rows; r++) begin
			if (r < c.glyph_offset_y &&
			    (c.glyph_offset_y > 8 || $urandom_range(0, 3) != 0)) begin
				// one long repeat closes a skipped row whatever the width
				push(CMD_DATA, 8'hff);
				push(CMD_DATA, pair_byte());
			end else begin
				cols = 0;
				do begin
					if ($urandom_range(0, 19) == 0) begin
						if ($urandom_range(0, 7) == 0)
							push(CMD_START, 8'($urandom));
						else
							push(CMD_DATA, 8'($urandom));
					end
					if ($urandom_range(0, 1) != 0) begin
						cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
						                                  : $urandom_range(1, 8);
						hb = 8'(cnt - 1);
						hb[7] = 1'b1;
						push(CMD_DATA, hb);
						push(CMD_DATA, pair_byte());
					end else begin
						cnt = ($urandom_range(0, 59) == 0) ? $urandom_range(1, 128)
						                                   : $urandom_range(1, 5);
						hb = 8'(cnt - 1);
						push(CMD_DATA, hb);
						repeat (cnt) push(CMD_DATA, pair_byte());
					end
					cols += 2 * cnt;
				end while (cols < gw);
			end
		end
	endtask

	initial begin : stimulus
		cfg_t d;
		cfg_t c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes while idle, then a start against zero width
		push(CMD_DATA, 8'h00);
		push(CMD_DATA, 8'hff);
		push(CMD_START, 8'ha5);
		settle(6);

		d                = '0;
		d.clip_left      = 16'sd0;
		d.clip_right     = 16'sd7;
		d.clip_top       = 16'sd5;
		d.clip_bottom    = 16'sd6;
		d.glyph_offset_x = 8'd1;
		d.glyph_offset_y = 8'd1;
		d.glyph_width    = 8'd4;
		d.glyph_alpha    = 8'hff;
		load_window(d);
		push(CMD_START, 8'h00);
		push(CMD_DATA, 8'h81);
		push(CMD_DATA, 8'h5a);
		// clipped single pixel with zero alpha, then an opaque right pixel
		push(CMD_DATA, 8'h01);
		push(CMD_DATA, 8'h0f);
		push(CMD_DATA, 8'hf0);
		// longest repeat runs off the right edge and ends the glyph
		push(CMD_DATA, 8'hff);
		push(CMD_DATA, 8'h37);
		push(CMD_DATA, 8'h80);
		settle(6);

		d.glyph_alpha = 8'h00;
		load_window(d);
		push(CMD_START, 8'h00);
		settle(6);

		d.glyph_alpha = 8'h01;
		d.clip_bottom = 16'sd4;
		load_window(d);
		push(CMD_START, 8'h00);
		settle(6);

		d.clip_left      = -16'sd32768;
		d.clip_right     = 16'sd32767;
		d.clip_top       = -16'sd32768;
		d.clip_bottom    = -16'sd32767;
		d.glyph_offset_x = 8'hff;
		d.glyph_offset_y = 8'h00;
		d.glyph_width    = 8'hff;
		d.glyph_alpha    = 8'h80;
		load_window(d);
		push(CMD_START, 8'hff);
		push(CMD_DATA, 8'h00);
		push(CMD_DATA, 8'h00);
		push(CMD_DATA, 8'hff);
		push(CMD_DATA, 8'hff);
		push(CMD_DATA, 8'h80);
		push(CMD_DATA, 8'h10);
		push(CMD_DATA, 8'hff);
		push(CMD_DATA, 8'h01);
		settle(6);

		while (items_sent < 1500) begin
			c = rand_cfg();
			load_window(c);
			repeat ($urandom_range(1, 3)) send_glyph(c);
			settle(6);
		end

		settle(20);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
